>>> design/ohrt_pkg.sv
package ohrt_pkg;

  // Table geometry
  localparam int unsigned ENTRIES  = 8;
  localparam int unsigned MAX_ARGS = 32;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned OP_W     = 16;

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_OVERLAP  = 3'd1,
    ST_FULL     = 3'd2,
    ST_MISS     = 3'd3,
    ST_INVERTED = 3'd4,
    ST_ARGS     = 3'd5
  } status_e;

  // Request fields broadcast to every cell
  typedef struct packed {
    cmd_e            cmd;
    logic [OP_W-1:0] lo;
    logic [OP_W-1:0] hi;
    logic [OP_W-1:0] op;
  } query_t;

  // Search token that walks down the chain
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } token_t;

  // Table update issued when an item completes
  typedef struct packed {
    logic             ins_en;
    logic             shift_en;
    logic [IDX_W-1:0] pos;
  } update_t;

endpackage

>>> design/ohrt_cell.sv
module ohrt_cell
  import ohrt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic [CNT_W-1:0] count_i,
  input  query_t           query_i,
  input  token_t           tok_i,
  output token_t           tok_o,
  input  update_t          upd_i,
  input  logic [OP_W-1:0]  nbr_start_i,
  input  logic [OP_W-1:0]  nbr_end_i,
  output logic [OP_W-1:0]  start_o,
  output logic [OP_W-1:0]  end_o
);

  logic [OP_W-1:0] start_q, start_d;
  logic [OP_W-1:0] end_q, end_d;
  token_t          tok_q, tok_d;
  logic            active;
  logic            match;

  // Entry holds a live range only below the fill count
  assign active = CNT_W'(cell_idx_i) < count_i;

  // Per-command compare against this entry
  always_comb begin
    case (query_i.cmd)
      CMD_INSERT: match = (query_i.lo <= end_q) && (query_i.hi >= start_q);
      CMD_REMOVE: match = (query_i.lo == start_q) && (query_i.hi == end_q);
      CMD_LOOKUP: match = (query_i.op >= start_q) && (query_i.op <= end_q);
      default:    match = 1'b0;
    endcase
  end

  // Token: first match wins, later cells pass it on
  always_comb begin
    tok_d       = tok_i;
    tok_d.found = 1'b0;
    tok_d.idx   = '0;
    if (tok_i.valid) begin
      if (tok_i.found) begin
        tok_d.found = 1'b1;
        tok_d.idx   = tok_i.idx;
      end else if (active && match) begin
        tok_d.found = 1'b1;
        tok_d.idx   = cell_idx_i;
      end
    end
  end

  // Append writes this cell, compaction pulls from the upper neighbor
  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    if (upd_i.ins_en && (upd_i.pos == cell_idx_i)) begin
      start_d = query_i.lo;
      end_d   = query_i.hi;
    end else if (upd_i.shift_en && (cell_idx_i >= upd_i.pos)) begin
      start_d = nbr_start_i;
      end_d   = nbr_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

  assign tok_o   = tok_q;
  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

>>> design/op_range_handler_table.sv
// Channel  Dir  Signals                      Contents
// s_axis   in   tvalid/tready/tdata/tuser    request item: ranges, opcode, arg count
// m_axis   out  tvalid/tready/tdata          result item: status, hit, index, count
//
// One item at a time: a search token walks the row of ENTRIES cells, one cell
// per cycle; the finished token is captured as it leaves the last cell,
// and the next item is taken only after the previous one commits.
// The table update (append or compaction shift) commits in the final cycle.
// Reset clears the fill count and the control; stored ranges are not cleared.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in its final cycle until the output register frees.
module op_range_handler_table
  import ohrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // range_low, range_high, query_op, num_args
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status, hit, entry_index, entry_count, zero pad
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  query_t           query_q;
  logic [7:0]       args_q;
  logic             start_q;
  logic [CNT_W-1:0] count_q, count_d;
  token_t           res_q;
  logic             out_valid_q;
  logic [15:0]      out_data_q, out_data_d;
  logic             in_fire;
  logic             commit;
  logic             inverted;
  update_t          upd;
  status_e          status;
  logic             hit;

  token_t          tok [ENTRIES+1];
  logic [OP_W-1:0] cell_start [ENTRIES];
  logic [OP_W-1:0] cell_end [ENTRIES];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  // Token injection into the first cell
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_q;
  end

  // Row of cells, each but the last pulling from its upper neighbor on compaction
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [OP_W-1:0] nbr_start;
    logic [OP_W-1:0] nbr_end;
    if (g == ENTRIES - 1) begin : g_last
      assign nbr_start = cell_start[g];
      assign nbr_end   = cell_end[g];
    end else begin : g_mid
      assign nbr_start = cell_start[g+1];
      assign nbr_end   = cell_end[g+1];
    end
    ohrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IDX_W'(g)),
      .count_i     (count_q),
      .query_i     (query_q),
      .tok_i       (tok[g]),
      .tok_o       (tok[g+1]),
      .upd_i       (upd),
      .nbr_start_i (nbr_start),
      .nbr_end_i   (nbr_end),
      .start_o     (cell_start[g]),
      .end_o       (cell_end[g])
    );
  end

  // Result and table update from the finished token
  assign inverted = query_q.lo > query_q.hi;

  always_comb begin
    status       = ST_MISS;
    hit          = 1'b0;
    upd          = '0;
    count_d      = count_q;
    case (query_q.cmd)
      CMD_INSERT: begin
        if (inverted) begin
          status = ST_INVERTED;
        end else if (res_q.found) begin
          status = ST_OVERLAP;
        end else if (count_q >= CNT_W'(ENTRIES)) begin
          status = ST_FULL;
        end else begin
          status     = ST_DONE;
          upd.ins_en = commit;
          upd.pos    = IDX_W'(count_q);
          count_d    = count_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (inverted) begin
          status = ST_INVERTED;
        end else if (res_q.found) begin
          status       = ST_DONE;
          upd.shift_en = commit;
          upd.pos      = res_q.idx;
          count_d      = count_q - 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (args_q > 8'(MAX_ARGS)) begin
          status = ST_ARGS;
        end else if (res_q.found) begin
          status = ST_DONE;
          hit    = 1'b1;
        end
      end
      default: status = ST_MISS;
    endcase
    out_data_d = {5'd0, 4'(count_d), (hit ? 3'(res_q.idx) : 3'd0), hit, status};
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_SCAN;
      S_SCAN: if (tok[ENTRIES].valid) state_d = S_FIN;
      S_FIN:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, finished token and output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      query_q.cmd <= cmd_e'(s_axis_tuser);
      query_q.lo  <= s_axis_tdata[15:0];
      query_q.hi  <= s_axis_tdata[31:16];
      query_q.op  <= s_axis_tdata[47:32];
      args_q      <= s_axis_tdata[55:48];
    end
    if ((state_q == S_SCAN) && tok[ENTRIES].valid) begin
      res_q <= tok[ENTRIES];
    end
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sim/range_table_monitor.sv
// Watches both channels of the opcode range table, keeps a shadow copy of
// the table and compares every result item against the oldest prediction.
module range_table_monitor
  import ohrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [55:0] req_data_i,    // range_low, range_high, query_op, num_args
  input  logic [1:0]  req_user_i,    // command
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [15:0] rsp_data_i,    // status, hit, entry_index, entry_count
  output int          fail_count_o,
  output int          outstanding_o
);

  typedef struct packed {
    status_e          status;
    logic             hit;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } table_result_t;

  // Shadow of the range table
  logic [OP_W-1:0] shadow_lo [ENTRIES];
  logic [OP_W-1:0] shadow_hi [ENTRIES];
  int              shadow_used;

  table_result_t   expected_q [$];
  int              fails;

  assign fail_count_o = fails;

  // Applies one request to the shadow table and returns its result
  function automatic table_result_t resolve_request(input cmd_e cmd,
                                                    input logic [OP_W-1:0] lo,
                                                    input logic [OP_W-1:0] hi,
                                                    input logic [OP_W-1:0] op,
                                                    input logic [7:0] args);
    table_result_t res;
    bit            done;
    res = '{status: ST_MISS, hit: 1'b0, index: '0, count: '0};
    done = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (lo > hi) begin
          res.status = ST_INVERTED;
        end else begin
          // overlap wins over a full table
          for (int i = 0; i < shadow_used; i++) begin
            if (!done && lo <= shadow_hi[i] && hi >= shadow_lo[i]) begin
              res.status = ST_OVERLAP;
              done = 1'b1;
            end
          end
          if (!done) begin
            if (shadow_used >= ENTRIES) begin
              res.status = ST_FULL;
            end else begin
              shadow_lo[shadow_used] = lo;
              shadow_hi[shadow_used] = hi;
              shadow_used++;
              res.status = ST_DONE;
            end
          end
        end
      end
      CMD_REMOVE: begin
        if (lo > hi) begin
          res.status = ST_INVERTED;
        end else begin
          for (int i = 0; i < shadow_used; i++) begin
            if (!done && shadow_lo[i] == lo && shadow_hi[i] == hi) begin
              // compact: later entries move down one place
              for (int j = i; j + 1 < shadow_used; j++) begin
                shadow_lo[j] = shadow_lo[j + 1];
                shadow_hi[j] = shadow_hi[j + 1];
              end
              done = 1'b1;
            end
          end
          if (done) begin
            shadow_used--;
            res.status = ST_DONE;
          end
        end
      end
      CMD_LOOKUP: begin
        if (args > MAX_ARGS) begin
          res.status = ST_ARGS;
        end else begin
          for (int i = 0; i < shadow_used; i++) begin
            if (!done && op >= shadow_lo[i] && op <= shadow_hi[i]) begin
              res.status = ST_DONE;
              res.hit    = 1'b1;
              res.index  = i[IDX_W-1:0];
              done = 1'b1;
            end
          end
        end
      end
      default: res.status = ST_MISS;
    endcase
    res.count = shadow_used[CNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  initial begin
    fails = 0;
    shadow_used = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      shadow_used = 0;
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      // result side first: a result always belongs to an older item
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result item, expected none actual %h",
                   $time, rsp_data_i);
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, rsp_data_i[2:0]);
          check_field("hit", want.hit, rsp_data_i[3]);
          check_field("entry_index", want.index, rsp_data_i[4 +: IDX_W]);
          check_field("entry_count", want.count, rsp_data_i[4 + IDX_W +: CNT_W]);
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_q.push_back(resolve_request(cmd_e'(req_user_i), req_data_i[15:0],
                                             req_data_i[31:16], req_data_i[47:32],
                                             req_data_i[55:48]));
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

>>> sim/tb.sv
module tb;
  import ohrt_pkg::*;

  localparam int ITEMS_PER_PHASE = 270;
  localparam int HOLD_CYCLES     = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_NONE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_go = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  logic [31:0] recent_q [$];   // {high, low} of recently inserted ranges

  always #2 clk_i = ~clk_i;

  op_range_handler_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  range_table_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .outstanding_o(pending)
  );

  // Result side: random stalls, plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one item after an optional gap, returns at the accepting edge
  task automatic send_item(input cmd_e cmd, input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] op, input logic [7:0] args);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {args, op, hi, lo};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Mostly sensible table traffic: ranges that get inserted are later
  // removed or probed, with some noise and unused commands mixed in
  task automatic send_random();
    int unsigned pick;
    int          k;
    int          sum;
    logic [31:0] entry;
    logic [15:0] lo, hi, op;
    logic [7:0]  args;
    pick = $urandom_range(0, 99);
    lo = 16'($urandom);
    hi = 16'($urandom);
    op = 16'($urandom);
    args = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, MAX_ARGS)
                                           : $urandom_range(0, 255));
    if (pick < 40) begin
      if ($urandom_range(0, 9) != 0) begin
        sum = lo + $urandom_range(0, 2047);
        hi = (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
      end
      recent_q.push_back({hi, lo});
      if (recent_q.size() > 16) recent_q.pop_front();
      send_item(CMD_INSERT, lo, hi, op, args);
    end else if (pick < 62) begin
      if (recent_q.size() > 0 && $urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, recent_q.size() - 1);
        entry = recent_q[k];
        recent_q.delete(k);
        lo = entry[15:0];
        hi = entry[31:16];
      end
      send_item(CMD_REMOVE, lo, hi, op, args);
    end else if (pick < 95) begin
      if (recent_q.size() > 0 && $urandom_range(0, 99) < 70) begin
        entry = recent_q[$urandom_range(0, recent_q.size() - 1)];
        if (entry[31:16] >= entry[15:0]) begin
          sum = entry[15:0] + ($urandom % (entry[31:16] - entry[15:0] + 1));
          op = sum[15:0];
        end
      end
      send_item(CMD_LOOKUP, lo, hi, op, args);
    end else begin
      send_item(CMD_NONE, lo, hi, op, args);
    end
  endtask

  // Returns once every predicted result has been seen
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, every status
    send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 8'd0);
    send_item(CMD_INSERT, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF);
    send_item(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h00);
    send_item(CMD_INSERT, 16'h8000, 16'h7FFF, 16'h0000, 8'h00);
    send_item(CMD_REMOVE, 16'h0010, 16'h0001, 16'h0000, 8'h00);
    send_item(CMD_INSERT, 16'h0000, 16'hFFFF, 16'h0000, 8'h00);
    send_item(CMD_REMOVE, 16'h1000, 16'h1FFF, 16'h0000, 8'h00);
    send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 8'(MAX_ARGS));
    send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 8'(MAX_ARGS + 1));
    send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
    send_item(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    // fill the table to the brim
    for (int i = 1; i <= ENTRIES - 2; i++) begin
      send_item(CMD_INSERT, 16'(i * 16'h1000), 16'(i * 16'h1000 + 16'h0FFF), 16'h0000, 8'h00);
    end
    send_item(CMD_INSERT, 16'h7000, 16'h7FFF, 16'h0000, 8'h00);
    // overlapping and full at once: overlap is reported
    send_item(CMD_INSERT, 16'h6800, 16'h7800, 16'h0000, 8'h00);
    send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h6ABC, 8'd1);
    // remove from the middle shifts later entries down
    send_item(CMD_REMOVE, 16'h2000, 16'h2FFF, 16'h0000, 8'h00);
    send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h6ABC, 8'd1);
    send_item(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 8'd1);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_go <= 1'b1;
        end
        1: begin
          idle_pct = 70;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 70;
        end
        default: begin
          idle_pct = 34;
          stall_pct <= 34;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (ENTRIES + 12) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
